// ===== rtl/core/bounded_sequence_edit_engine_core_assert.svh =====
// Assertion macros shared by the core.
`ifndef BOUNDED_SEQUENCE_EDIT_ENGINE_CORE_ASSERT_SVH
`define BOUNDED_SEQUENCE_EDIT_ENGINE_CORE_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define BSEE_CHECK_NOW(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("bsee check failed");

// Condition must hold in the cycle after the trigger.
`define BSEE_CHECK_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("bsee check failed");

`endif

// ===== rtl/core/bsee_pkg.sv =====
package bsee_pkg;

    localparam int FIELD_W = 9;
    localparam int ID_W    = 6;
    localparam int BND_W   = 2 * FIELD_W;

    typedef enum logic [3:0] {
        OP_CLEAR    = 4'd0,
        OP_LOAD     = 4'd1,
        OP_INSERT   = 4'd2,
        OP_APPEND   = 4'd3,
        OP_REMOVE   = 4'd4,
        OP_RELOCATE = 4'd5,
        OP_EXCHANGE = 4'd6,
        OP_SWAP     = 4'd7,
        OP_READ     = 4'd8
    } op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHK0,
        ST_CHK1,
        ST_CHK2,
        ST_WR1,
        ST_WR2,
        ST_CLR,
        ST_SETUP,
        ST_P1,
        ST_P2,
        ST_FIN,
        ST_RES
    } state_t;

endpackage

// ===== rtl/core/bounded_sequence_edit_engine_core.sv =====
// Sequence edit engine: holds up to MAX_LEN node ids with per-id occurrence
// counts and lower/upper bounds, and applies one edit per input transfer,
// returning one result transfer. After reset the count and bound memories
// are swept to zero before the first item is taken. Insert, remove,
// relocate, exchange and swap ids rebuild the sequence through a scratch
// memory in two passes over the new length n. Clear sweeps the count
// memory. One item is in work at a time; the next is taken while a result
// still waits in the output register.
module bounded_sequence_edit_engine_core #(
    parameter int MAX_LEN    = 256,
    parameter int NODE_COUNT = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] op,
    input  logic [5:0] node,
    input  logic [5:0] node_b,
    input  logic [8:0] pos_a,
    input  logic [8:0] pos_b,
    input  logic [8:0] len_a,
    input  logic [8:0] len_b,
    input  logic       reverse_flag,
    input  logic [8:0] lower_bound,
    input  logic [8:0] upper_bound,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       applied,
    output logic [8:0] seq_length,
    output logic [5:0] read_node,
    output logic [8:0] read_count
);
    import bsee_pkg::*;
    `include "bounded_sequence_edit_engine_core_assert.svh"

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int NW = $clog2(NODE_COUNT);
    localparam int CW = ((LW > FIELD_W) ? LW : FIELD_W) + 2;

    state_t state_reg, state_next;

    logic [3:0]         op_reg;
    logic [ID_W-1:0]    node_reg, nodeb_reg;
    logic [FIELD_W-1:0] pa_reg, pb_reg, la_reg, lb_reg, lo_in_reg, hi_in_reg;
    logic               rev_reg;

    logic [LW-1:0]      len_reg, nl_reg, i_reg;
    logic [LW-1:0]      cnt_x_reg, cnt_y_reg;
    logic [FIELD_W-1:0] lo_x_reg, hi_x_reg;
    logic [ID_W-1:0]    sval_reg;
    logic               ok_reg;
    logic [NW-1:0]      clr_idx_reg;
    logic               p_vld_reg, p_lit_reg;
    logic [AW-1:0]      p_idx_reg;

    logic [LW-1:0]      e_reg [4];
    logic [AW-1:0]      k_reg [5];
    logic               dir_reg [5];
    logic               lit_reg [5];

    logic               out_valid_reg, applied_reg;
    logic [8:0]         slen_out_reg, rcnt_out_reg;
    logic [5:0]         rnode_out_reg;

    // memory ports
    logic               seq_we, scr_we, cnt_we, bnd_we;
    logic [AW-1:0]      seq_waddr, seq_raddr, scr_waddr, scr_raddr;
    logic [ID_W-1:0]    seq_wdata, seq_rdata, scr_wdata, scr_rdata;
    logic [NW-1:0]      cnt_waddr, cnt_raddr, bnd_waddr, bnd_raddr;
    logic [LW-1:0]      cnt_wdata, cnt_rdata;
    logic [BND_W-1:0]   bnd_wdata, bnd_rdata;

    bsee_ram #(.W(ID_W), .D(MAX_LEN)) u_seq_ram (
        .clk(clk), .we(seq_we), .waddr(seq_waddr), .wdata(seq_wdata),
        .raddr(seq_raddr), .rdata(seq_rdata)
    );
    bsee_ram #(.W(ID_W), .D(MAX_LEN)) u_scr_ram (
        .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
        .raddr(scr_raddr), .rdata(scr_rdata)
    );
    bsee_ram #(.W(LW), .D(NODE_COUNT)) u_cnt_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );
    bsee_ram #(.W(BND_W), .D(NODE_COUNT)) u_bnd_ram (
        .clk(clk), .we(bnd_we), .waddr(bnd_waddr), .wdata(bnd_wdata),
        .raddr(bnd_raddr), .rdata(bnd_rdata)
    );

    logic [NW-1:0] node_idx, nodeb_idx;
    logic          node_ok, nodeb_ok, clr_last, pass_busy, pass_done, res_go;

    assign node_idx  = NW'(node_reg);
    assign nodeb_idx = NW'(nodeb_reg);
    assign node_ok   = CW'(node_reg) < CW'(NODE_COUNT);
    assign nodeb_ok  = CW'(nodeb_reg) < CW'(NODE_COUNT);
    assign clr_last  = clr_idx_reg == NW'(NODE_COUNT - 1);
    assign pass_busy = i_reg < nl_reg;
    assign pass_done = !pass_busy && !p_vld_reg;
    assign res_go    = !out_valid_reg || out_ready;

    // ---------------- acceptance checks ----------------
    logic ok_calc;
    always_comb
    begin
        logic [CW-1:0] cx, cy, lox, hix, loy, hiy, ln, pa, pb, la, lb;
        cx  = CW'(cnt_x_reg);
        cy  = CW'(cnt_rdata);
        lox = CW'(lo_x_reg);
        hix = CW'(hi_x_reg);
        loy = CW'(bnd_rdata[BND_W-1:FIELD_W]);
        hiy = CW'(bnd_rdata[FIELD_W-1:0]);
        ln  = CW'(len_reg);
        pa  = CW'(pa_reg);
        pb  = CW'(pb_reg);
        la  = CW'(la_reg);
        lb  = CW'(lb_reg);
        unique case (op_reg)
            OP_CLEAR:    ok_calc = 1'b1;
            OP_LOAD:     ok_calc = node_ok;
            OP_INSERT:   ok_calc = node_ok && cx < hix && pa <= ln && ln < CW'(MAX_LEN);
            OP_APPEND:   ok_calc = node_ok && cx < hix && ln < CW'(MAX_LEN);
            OP_REMOVE:   ok_calc = pa < ln && cy > loy;
            OP_RELOCATE: ok_calc = pa + la <= ln && pb + la <= ln;
            OP_EXCHANGE: ok_calc = pa + la <= ln && pb + lb <= ln &&
                                   !(pa >= pb && pa < pb + lb) &&
                                   !(pb >= pa && pb < pa + la);
            OP_SWAP:     ok_calc = node_ok && nodeb_ok && cx >= loy && cy >= lox &&
                                   cx <= hiy && cy <= hix;
            OP_READ:     ok_calc = pa < ln;
            default:     ok_calc = 1'b0;
        endcase
    end

    // ---------------- rebuild map setup ----------------
    // new[i] = old[K +/- i] per segment; segment s covers i below e[s]
    logic [LW-1:0] se [4];
    logic [AW-1:0] sk [5];
    logic          sd [5];
    logic          sl [5];
    logic [LW-1:0] snl;
    always_comb
    begin
        logic [LW-1:0] pa, pb, la, p1, s1, p2, s2, e2;
        logic [AW-1:0] apa, apb, ala, ap1, as1, ap2, as2, ae2;
        pa  = LW'(pa_reg);
        pb  = LW'(pb_reg);
        la  = LW'(la_reg);
        apa = AW'(pa_reg);
        apb = AW'(pb_reg);
        ala = AW'(la_reg);
        if (pa_reg < pb_reg)
        begin
            p1 = pa; s1 = la; p2 = pb; s2 = LW'(lb_reg);
        end
        else
        begin
            p1 = pb; s1 = LW'(lb_reg); p2 = pa; s2 = la;
        end
        e2  = p2 - s1 + s2;
        ap1 = AW'(p1);
        as1 = AW'(s1);
        ap2 = AW'(p2);
        as2 = AW'(s2);
        ae2 = AW'(e2);
        for (int s = 0; s < 4; s++)
        begin
            se[s] = '0;
        end
        for (int s = 0; s < 5; s++)
        begin
            sk[s] = '0;
            sd[s] = 1'b0;
            sl[s] = 1'b0;
        end
        snl = len_reg;
        unique case (op_reg)
            OP_INSERT:
            begin
                se[0] = pa;
                se[1] = pa + LW'(1);
                se[2] = pa + LW'(1);
                se[3] = pa + LW'(1);
                sl[1] = 1'b1;
                sk[4] = '1;
                snl   = len_reg + LW'(1);
            end
            OP_REMOVE:
            begin
                se[0] = pa;
                se[1] = pa;
                se[2] = pa;
                se[3] = pa;
                sk[4] = AW'(1);
                snl   = len_reg - LW'(1);
            end
            OP_RELOCATE:
            begin
                if (pb_reg <= pa_reg)
                begin
                    se[0] = pb;
                    se[1] = pb + la;
                    se[2] = pa + la;
                    se[3] = pa + la;
                    sd[1] = rev_reg;
                    sk[1] = rev_reg ? apa + ala - AW'(1) + apb : apa - apb;
                    sk[2] = AW'(0) - ala;
                end
                else
                begin
                    se[0] = pa;
                    se[1] = pb;
                    se[2] = pb + la;
                    se[3] = pb + la;
                    sk[1] = ala;
                    sd[2] = rev_reg;
                    sk[2] = rev_reg ? apa + ala - AW'(1) + apb : apa - apb;
                end
            end
            OP_EXCHANGE:
            begin
                se[0] = p1;
                se[1] = p1 + s2;
                se[2] = e2;
                se[3] = p2 + s2;
                sd[1] = rev_reg;
                sk[1] = rev_reg ? ap2 + as2 - AW'(1) + ap1 : ap2 - ap1;
                sk[2] = as1 - as2;
                sd[3] = rev_reg;
                sk[3] = rev_reg ? ap1 + as1 - AW'(1) + ae2 : ap1 - ae2;
            end
            default:
            begin
                snl = len_reg;
            end
        endcase
    end

    // source address of the element at new position i
    logic [AW-1:0] src_addr;
    logic          src_lit;
    always_comb
    begin
        logic [2:0] seg;
        priority if (i_reg < e_reg[0]) seg = 3'd0;
        else if (i_reg < e_reg[1])     seg = 3'd1;
        else if (i_reg < e_reg[2])     seg = 3'd2;
        else if (i_reg < e_reg[3])     seg = 3'd3;
        else                           seg = 3'd4;
        src_addr = dir_reg[seg] ? k_reg[seg] - AW'(i_reg) : k_reg[seg] + AW'(i_reg);
        src_lit  = lit_reg[seg];
    end

    logic [ID_W-1:0] swap_val;
    always_comb
    begin
        swap_val = scr_rdata;
        if (op_reg == OP_SWAP)
        begin
            if (scr_rdata == node_reg)
            begin
                swap_val = nodeb_reg;
            end
            else if (scr_rdata == nodeb_reg)
            begin
                swap_val = node_reg;
            end
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        seq_we     = 1'b0;
        seq_waddr  = p_idx_reg;
        seq_wdata  = swap_val;
        seq_raddr  = AW'(pa_reg);
        scr_we     = 1'b0;
        scr_waddr  = p_idx_reg;
        scr_wdata  = p_lit_reg ? node_reg : seq_rdata;
        scr_raddr  = AW'(i_reg);
        cnt_we     = 1'b0;
        cnt_waddr  = clr_idx_reg;
        cnt_wdata  = '0;
        cnt_raddr  = node_idx;
        bnd_we     = 1'b0;
        bnd_waddr  = clr_idx_reg;
        bnd_wdata  = '0;
        bnd_raddr  = node_idx;
        unique case (state_reg)
            ST_INIT:
            begin
                cnt_we = 1'b1;
                bnd_we = 1'b1;
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHK0;
                end
            end
            ST_CHK0:
            begin
                state_next = ST_CHK1;
            end
            ST_CHK1:
            begin
                cnt_raddr  = (op_reg == OP_REMOVE) ? NW'(seq_rdata) : nodeb_idx;
                bnd_raddr  = cnt_raddr;
                state_next = ST_CHK2;
            end
            ST_CHK2:
            begin
                if (!ok_calc)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    unique case (op_reg)
                        OP_CLEAR:                        state_next = ST_CLR;
                        OP_RELOCATE, OP_EXCHANGE:        state_next = ST_SETUP;
                        OP_LOAD, OP_INSERT, OP_APPEND,
                        OP_REMOVE, OP_SWAP:              state_next = ST_WR1;
                        default:                         state_next = ST_FIN;
                    endcase
                end
            end
            ST_WR1:
            begin
                unique case (op_reg)
                    OP_LOAD:
                    begin
                        bnd_we     = 1'b1;
                        bnd_waddr  = node_idx;
                        bnd_wdata  = {lo_in_reg, hi_in_reg};
                        state_next = ST_FIN;
                    end
                    OP_APPEND:
                    begin
                        cnt_we     = 1'b1;
                        cnt_waddr  = node_idx;
                        cnt_wdata  = cnt_x_reg + LW'(1);
                        seq_we     = 1'b1;
                        seq_waddr  = AW'(len_reg);
                        seq_wdata  = node_reg;
                        state_next = ST_FIN;
                    end
                    OP_INSERT:
                    begin
                        cnt_we     = 1'b1;
                        cnt_waddr  = node_idx;
                        cnt_wdata  = cnt_x_reg + LW'(1);
                        state_next = ST_SETUP;
                    end
                    OP_REMOVE:
                    begin
                        cnt_we     = 1'b1;
                        cnt_waddr  = NW'(sval_reg);
                        cnt_wdata  = cnt_y_reg - LW'(1);
                        state_next = ST_SETUP;
                    end
                    default:
                    begin
                        cnt_we     = 1'b1;
                        cnt_waddr  = node_idx;
                        cnt_wdata  = cnt_y_reg;
                        state_next = ST_WR2;
                    end
                endcase
            end
            ST_WR2:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = nodeb_idx;
                cnt_wdata  = cnt_x_reg;
                state_next = ST_SETUP;
            end
            ST_CLR:
            begin
                cnt_we = 1'b1;
                if (clr_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_P1;
            end
            ST_P1:
            begin
                seq_raddr = src_addr;
                scr_we    = p_vld_reg;
                if (pass_done)
                begin
                    state_next = ST_P2;
                end
            end
            ST_P2:
            begin
                seq_we = p_vld_reg;
                if (pass_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (res_go)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            clr_idx_reg   <= '0;
            i_reg         <= '0;
            p_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_INIT || state_reg == ST_CLR)
            begin
                clr_idx_reg <= clr_last ? '0 : clr_idx_reg + NW'(1);
            end
            if (state_reg == ST_CLR)
            begin
                len_reg <= '0;
            end
            if (state_reg == ST_WR1 && op_reg == OP_APPEND)
            begin
                len_reg <= len_reg + LW'(1);
            end
            if (state_reg == ST_SETUP)
            begin
                i_reg     <= '0;
                p_vld_reg <= 1'b0;
            end
            if (state_reg == ST_P1 || state_reg == ST_P2)
            begin
                p_vld_reg <= pass_busy;
                if (pass_busy)
                begin
                    i_reg <= i_reg + LW'(1);
                end
                else if (pass_done)
                begin
                    i_reg <= '0;
                end
            end
            if (state_reg == ST_P2 && pass_done)
            begin
                len_reg <= nl_reg;
            end
            if (state_reg == ST_RES && res_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            op_reg    <= op;
            node_reg  <= node;
            nodeb_reg <= node_b;
            pa_reg    <= pos_a;
            pb_reg    <= pos_b;
            la_reg    <= len_a;
            lb_reg    <= len_b;
            rev_reg   <= reverse_flag;
            lo_in_reg <= lower_bound;
            hi_in_reg <= upper_bound;
        end
        if (state_reg == ST_CHK1)
        begin
            cnt_x_reg <= cnt_rdata;
            lo_x_reg  <= bnd_rdata[BND_W-1:FIELD_W];
            hi_x_reg  <= bnd_rdata[FIELD_W-1:0];
            sval_reg  <= seq_rdata;
        end
        if (state_reg == ST_CHK2)
        begin
            cnt_y_reg <= cnt_rdata;
            ok_reg    <= ok_calc;
        end
        if (state_reg == ST_SETUP)
        begin
            nl_reg <= snl;
            for (int s = 0; s < 4; s++)
            begin
                e_reg[s] <= se[s];
            end
            for (int s = 0; s < 5; s++)
            begin
                k_reg[s]   <= sk[s];
                dir_reg[s] <= sd[s];
                lit_reg[s] <= sl[s];
            end
        end
        if ((state_reg == ST_P1 || state_reg == ST_P2) && pass_busy)
        begin
            p_idx_reg <= AW'(i_reg);
            p_lit_reg <= (state_reg == ST_P1) && src_lit;
        end
        if (state_reg == ST_RES && res_go)
        begin
            applied_reg   <= ok_reg;
            slen_out_reg  <= 9'(len_reg);
            rnode_out_reg <= (op_reg == OP_READ && ok_reg) ? sval_reg : '0;
            rcnt_out_reg  <= node_ok ? 9'(cnt_rdata) : '0;
        end
    end

    assign in_ready   = state_reg == ST_IDLE;
    assign out_valid  = out_valid_reg;
    assign applied    = applied_reg;
    assign seq_length = slen_out_reg;
    assign read_node  = rnode_out_reg;
    assign read_count = rcnt_out_reg;

    `BSEE_CHECK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `BSEE_CHECK_NOW(a_len_in_range, clk, rst_n, 1'b1, len_reg <= LW'(MAX_LEN))
    `BSEE_CHECK_NOW(a_pass_pipe, clk, rst_n, p_vld_reg, state_reg == ST_P1 || state_reg == ST_P2)

endmodule

// ===== rtl/core/bsee_ram.sv =====
module bsee_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
